@@ rtl/core/swpp_pkg.sv @@
`timescale 1ns / 1ps
// Package for the sliding-window percentile/peak core: payload structs,
// register and opcode constants, controller state and command types. No dependencies.
package swpp_pkg;

  localparam int SAMPLE_BITS    = 32;
  localparam int WINDOW_MAX_DEF = 1024;
  localparam int PCT_W          = 17;
  localparam int CAP_W          = 11;
  localparam int HELD_W         = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 17;
  localparam int Q16_SHIFT      = 16;

  localparam logic [PCT_W-1:0] FULL_SCALE_Q16 = 17'd65536;
  localparam logic [PCT_W-1:0] PCT_RESET      = 17'd62259;
  localparam logic [CAP_W-1:0] CAP_RESET      = 11'd30;

  localparam logic [CFG_IDX_W-1:0] REG_PERCENTILE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b1;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] rx_sample;
    logic [SAMPLE_BITS-1:0] tx_sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] rx_percentile;
    logic [SAMPLE_BITS-1:0] tx_percentile;
    logic [SAMPLE_BITS-1:0] rx_peak;
    logic [SAMPLE_BITS-1:0] tx_peak;
    logic [HELD_W-1:0]      samples_held;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic push;    // write the sample pair
    logic setup;   // latch count, rank and start address
    logic scan;    // issue one read, advance address
    logic decide;  // settle one result bit
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic bit_last;
  } dp_status_t;

endpackage

@@ rtl/core/swpp_ctrl.sv @@
`timescale 1ns / 1ps
// Controller FSM for the percentile core: sequences push, setup, bitwise scan
// passes and result hand-off. Depends on swpp_pkg.
module swpp_ctrl import swpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  input  logic       out_free,
  output logic       out_load
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_op == OP_REPORT) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = status.empty ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = status.bit_last ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.push = in_valid && in_op == OP_PUSH;
      end
      ST_SETUP:  cmd.setup  = 1'b1;
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_DRAIN:  ;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_DONE:   out_load   = out_free;
      default:   ;
    endcase
  end

endmodule

@@ rtl/core/swpp_datapath.sv @@
`timescale 1ns / 1ps
// Datapath for the percentile core: sample memories, window pointers, rank
// computation and radix-select counters for both channels. Depends on swpp_pkg.
module swpp_datapath import swpp_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [SAMPLE_BITS-1:0] rx_sample,
  input  logic [SAMPLE_BITS-1:0] tx_sample,
  input  logic [PCT_W-1:0]       percentile_q16,
  input  logic [CAP_W-1:0]       window_capacity,
  output out_item_t              result
);

  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PRD_W = PCT_W + CNT_W;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(WINDOW_MAX - 1);

  logic [SAMPLE_BITS-1:0] rx_mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] tx_mem [WINDOW_MAX];

  logic [IDX_W-1:0] wp, addr, start_addr;
  logic [CNT_W-1:0] fill, n_reg, scan_cnt;
  logic [CNT_W-1:0] rx_rank, tx_rank, rx_cnt0, tx_cnt0;
  logic [SAMPLE_BITS-1:0] rx_rd, tx_rd, rx_prefix, tx_prefix, rx_max, tx_max;
  logic [SAMPLE_BITS-1:0] bit_sel, hi_mask;
  logic rd_vld;

  logic [EXT_W-1:0] cap_ext;
  logic [CNT_W-1:0] cap_eff, held, rank_next;
  logic [CNT_W:0]   held_plus, wp_ext, start_ext;
  logic [PRD_W-1:0] prod, k;

  // Window bookkeeping
  always_comb begin
    cap_ext = EXT_W'(window_capacity);
    if (cap_ext == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > EXT_W'(WINDOW_MAX)) begin
      cap_eff = CNT_W'(WINDOW_MAX);
    end else begin
      cap_eff = CNT_W'(cap_ext);
    end
    held      = (fill < cap_eff) ? fill : cap_eff;
    held_plus = {1'b0, held} + (CNT_W+1)'(1);
    wp_ext    = (CNT_W+1)'(wp);
    if (wp_ext >= {1'b0, held}) begin
      start_ext = wp_ext - {1'b0, held};
    end else begin
      start_ext = wp_ext + (CNT_W+1)'(WINDOW_MAX) - {1'b0, held};
    end
  end

  // Nearest rank: ceil(p*N)-1 with p in Q16
  always_comb begin
    prod = PRD_W'(percentile_q16) * PRD_W'(held);
    k    = (prod + PRD_W'((1 << Q16_SHIFT) - 1)) >> Q16_SHIFT;
    if (percentile_q16 == '0 || held == '0) begin
      rank_next = '0;
    end else if (percentile_q16 >= FULL_SCALE_Q16) begin
      rank_next = held - CNT_W'(1);
    end else begin
      rank_next = CNT_W'(k) - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rx_mem[wp] <= rx_sample;
      tx_mem[wp] <= tx_sample;
    end
    rx_rd <= rx_mem[addr];
    tx_rd <= tx_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      fill   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      if (cmd.push) begin
        wp   <= (wp == LAST_POS) ? '0 : wp + IDX_W'(1);
        fill <= (held_plus < {1'b0, cap_eff}) ? CNT_W'(held_plus) : cap_eff;
      end
    end
  end

  logic rx_hit, tx_hit;
  always_comb begin
    rx_hit = (((rx_rd ^ rx_prefix) & hi_mask) == '0) && ((rx_rd & bit_sel) == '0);
    tx_hit = (((tx_rd ^ tx_prefix) & hi_mask) == '0) && ((tx_rd & bit_sel) == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      n_reg      <= held;
      start_addr <= IDX_W'(start_ext);
      addr       <= IDX_W'(start_ext);
      scan_cnt   <= '0;
      rx_rank    <= rank_next;
      tx_rank    <= rank_next;
      rx_cnt0    <= '0;
      tx_cnt0    <= '0;
      rx_prefix  <= '0;
      tx_prefix  <= '0;
      rx_max     <= '0;
      tx_max     <= '0;
      bit_sel    <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      hi_mask    <= '0;
    end else begin
      if (cmd.scan) begin
        addr     <= (addr == LAST_POS) ? '0 : addr + IDX_W'(1);
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      if (rd_vld) begin
        if (rx_hit) rx_cnt0 <= rx_cnt0 + CNT_W'(1);
        if (tx_hit) tx_cnt0 <= tx_cnt0 + CNT_W'(1);
        if (rx_rd > rx_max) rx_max <= rx_rd;
        if (tx_rd > tx_max) tx_max <= tx_rd;
      end
      if (cmd.decide) begin
        // rank falls among the zeros of this bit, or skip past them
        if (rx_rank >= rx_cnt0) begin
          rx_prefix <= rx_prefix | bit_sel;
          rx_rank   <= rx_rank - rx_cnt0;
        end
        if (tx_rank >= tx_cnt0) begin
          tx_prefix <= tx_prefix | bit_sel;
          tx_rank   <= tx_rank - tx_cnt0;
        end
        rx_cnt0  <= '0;
        tx_cnt0  <= '0;
        hi_mask  <= hi_mask | bit_sel;
        bit_sel  <= bit_sel >> 1;
        addr     <= start_addr;
        scan_cnt <= '0;
      end
    end
  end

  always_comb begin
    status.empty     = (held == '0);
    status.scan_last = (scan_cnt == n_reg - CNT_W'(1));
    status.bit_last  = bit_sel[0];
    result.rx_percentile = rx_prefix;
    result.tx_percentile = tx_prefix;
    result.rx_peak       = rx_max;
    result.tx_peak       = tx_max;
    result.samples_held  = HELD_W'(n_reg);
  end

endmodule

@@ rtl/core/sliding_window_percentile_peak_core.sv @@
`timescale 1ns / 1ps
// Top level of the sliding-window percentile/peak core: config registers,
// output register, controller and datapath. Depends on swpp_pkg, swpp_ctrl, swpp_datapath.
//
// Two windows (receive, transmit) of up to WINDOW_MAX samples each, held in
// one single-port-read memory per channel. A push (op 0) writes both samples
// in the transfer cycle and produces no result. A report (op 1) returns the
// nearest-rank percentile, rank ceil(p*N)-1, and the peak of each window,
// plus N; an empty window reports zeros. The percentile is found by a radix
// select, one bit per pass from the MSB down; each pass reads all N entries
// once, one per cycle, counting the candidates with a zero in the current
// bit. Input ready is low while a report runs. A finished result sits in an
// output register, so the next item is taken while it waits. Configuration:
// index 0 percentile_q16, index 1 window_capacity; cfg_ready is always high.
module sliding_window_percentile_peak_core import swpp_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PCT_W-1:0] percentile_q16;
  logic [CAP_W-1:0] window_capacity;
  dp_cmd_t    cmd;
  dp_status_t status;
  out_item_t  result;
  logic       out_free, out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      percentile_q16  <= PCT_RESET;
      window_capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PERCENTILE: percentile_q16  <= cfg_data[PCT_W-1:0];
        REG_CAPACITY:   window_capacity <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= result;
  end

  swpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .out_free (out_free),
    .out_load (out_load)
  );

  swpp_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .rx_sample       (in_data.rx_sample),
    .tx_sample       (in_data.tx_sample),
    .percentile_q16  (percentile_q16),
    .window_capacity (window_capacity),
    .result          (result)
  );

endmodule

@@ verif/tb_sliding_window_percentile_peak_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_percentile_peak_core: directed table,
// then random phases under changing percentile and capacity settings.
// Depends on swpp_pkg and the core RTL only.
module tb_sliding_window_percentile_peak_core;
  import swpp_pkg::*;

  localparam int WMAX     = WINDOW_MAX_DEF;
  localparam int STALL_LIM = 300000;  // idle cycles allowed
  localparam int HOLD_LEN  = 4000;    // long receiver hold-off

  // directed table row kinds
  typedef enum logic [1:0] {ROW_ITEM, ROW_PCT, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_item_t  item;
    logic [CFG_DATA_W-1:0] value;
    bit        typed;     // expected result written in the row
    out_item_t result;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PERCENTILE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  sliding_window_percentile_peak_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the windows and registers.
  logic [SAMPLE_BITS-1:0] rx_win [WMAX];
  logic [SAMPLE_BITS-1:0] tx_win [WMAX];
  int unsigned wr_pos, fill;
  logic [PCT_W-1:0] pct_reg;
  logic [CAP_W-1:0] cap_reg;

  out_item_t report_q[$];   // reports awaiting their result
  int errors, mismatches, pushes, reports, results_seen, cfg_writes;
  bit quiet;                // no idling on either side
  bit hold_req;             // ask the receiver for a long hold-off
  bit hold_seen;

  function automatic int unsigned eff_cap();
    int unsigned c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > WMAX) c = WMAX;
    return c;
  endfunction

  function automatic int unsigned held();
    int unsigned c;
    c = eff_cap();
    return (fill < c) ? fill : c;
  endfunction

  // Nearest-rank pick over the newest n samples of one channel.
  function automatic void rank_pick(bit is_tx, int unsigned n,
                                    output logic [SAMPLE_BITS-1:0] pct,
                                    output logic [SAMPLE_BITS-1:0] peak);
    logic [SAMPLE_BITS-1:0] vals[$];
    longint unsigned k;
    int unsigned idx, pos;
    vals = {};
    for (int unsigned i = 1; i <= n; i++) begin
      pos = (wr_pos + WMAX - i) % WMAX;
      vals = {vals, (is_tx ? tx_win[pos] : rx_win[pos])};
    end
    if (n == 0) begin
      pct = '0;
      peak = '0;
      return;
    end
    vals.sort();
    peak = vals[n-1];
    if (pct_reg == 0) idx = 0;
    else if (pct_reg >= FULL_SCALE_Q16) idx = n - 1;
    else begin
      k = (longint'(pct_reg) * n + 65535) >> Q16_SHIFT;
      idx = 32'(k) - 32'd1;
      if (idx >= n) idx = n - 1;
    end
    pct = vals[idx];
  endfunction

  function automatic out_item_t window_report();
    out_item_t r;
    int unsigned n;
    n = held();
    rank_pick(1'b0, n, r.rx_percentile, r.rx_peak);
    rank_pick(1'b1, n, r.tx_percentile, r.tx_peak);
    r.samples_held = n[HELD_W-1:0];
    return r;
  endfunction

  // Update the shadow state for one accepted transfer.
  function automatic void absorb(in_item_t it);
    int unsigned n;
    if (it.op == OP_PUSH) begin
      rx_win[wr_pos] = it.rx_sample;
      tx_win[wr_pos] = it.tx_sample;
      wr_pos = (wr_pos + 1) % WMAX;
      n = held() + 1;
      fill = (n < eff_cap()) ? n : eff_cap();
      pushes++;
    end else begin
      report_q = {report_q, window_report()};
      reports++;
    end
  endfunction

  // Offer one item, hold it until taken, then, unless quiet, sometimes idle.
  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    absorb(it);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drain all results, then give the core time to settle a push.
  task automatic go_idle();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    go_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PERCENTILE) pct_reg = val[PCT_W-1:0];
    else cap_reg = val[CAP_W-1:0];
    cfg_writes++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 15);  // duplicates exercise ties
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
        hold_seen = 1'b1;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Result checker: compare each result transfer with the oldest report.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (report_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %p", out_data);
      end else begin
        want = report_q[0];
        report_q.delete(0);
        if (out_data.rx_percentile !== want.rx_percentile ||
            out_data.tx_percentile !== want.tx_percentile ||
            out_data.rx_peak !== want.rx_peak || out_data.tx_peak !== want.tx_peak ||
            out_data.samples_held !== want.samples_held) begin
          mismatches++;
          errors++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected %p got %p", $time, want, out_data);
        end
      end
    end
  end

  // Watchdog: any transfer resets the idle count.
  int stall_cnt;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIM) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIM);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic row_t item_row(logic op, logic [31:0] rx, logic [31:0] tx);
    row_t r;
    r.kind = ROW_ITEM;
    r.item.op = op;
    r.item.rx_sample = rx;
    r.item.tx_sample = tx;
    r.value = '0;
    r.typed = 1'b0;
    r.result = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(row_kind_t k, logic [CFG_DATA_W-1:0] v);
    row_t r;
    r = item_row(OP_PUSH, '0, '0);
    r.kind = k;
    r.value = v;
    return r;
  endfunction

  function automatic row_t typed_row(out_item_t res);
    row_t r;
    r = item_row(OP_REPORT, '0, '0);
    r.typed = 1'b1;
    r.result = res;
    return r;
  endfunction

  initial begin
    row_t tbl[$];
    out_item_t got;
    in_item_t it;
    int unsigned cap, n_items, rep_pct;

    wr_pos = 0; fill = 0;
    pct_reg = PCT_RESET;
    cap_reg = CAP_RESET;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_seen = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty window, extremes, every rank mode, capacity edges.
    tbl = {tbl, typed_row('0)};                               // empty window
    tbl = {tbl, item_row(OP_PUSH, 32'hFFFF_FFFF, 32'h0)};
    tbl = {tbl, typed_row('{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 11'd1})};
    tbl = {tbl, item_row(OP_PUSH, 32'h0, 32'hFFFF_FFFF)};
    tbl = {tbl, item_row(OP_PUSH, 32'd12345, 32'd54321)};
    tbl = {tbl, item_row(OP_REPORT, '0, '0)};
    tbl = {tbl, cfg_row(ROW_PCT, 17'd0)};                     // minimum
    tbl = {tbl, item_row(OP_REPORT, '0, '0)};
    tbl = {tbl, cfg_row(ROW_PCT, FULL_SCALE_Q16)};            // maximum
    tbl = {tbl, item_row(OP_REPORT, '0, '0)};
    tbl = {tbl, cfg_row(ROW_PCT, 17'h1FFFF)};                 // above full scale
    tbl = {tbl, item_row(OP_REPORT, '0, '0)};
    tbl = {tbl, cfg_row(ROW_CAP, 17'd0)};                     // zero acts as one
    tbl = {tbl, item_row(OP_REPORT, '0, '0)};
    tbl = {tbl, cfg_row(ROW_CAP, 17'd2047)};                  // clamps to max window
    tbl = {tbl, item_row(OP_PUSH, 32'hA5A5_A5A5, 32'h5A5A_5A5A)};
    tbl = {tbl, item_row(OP_REPORT, '0, '0)};
    tbl = {tbl, cfg_row(ROW_PCT, 17'd1)};
    tbl = {tbl, cfg_row(ROW_CAP, 17'd1024)};
    tbl = {tbl, item_row(OP_PUSH, 32'd7, 32'd9)};
    tbl = {tbl, item_row(OP_REPORT, '0, '0)};
    tbl = {tbl, cfg_row(ROW_CAP, 17'd2)};                     // shrink while filled
    tbl = {tbl, item_row(OP_REPORT, '0, '0)};
    tbl = {tbl, cfg_row(ROW_CAP, 17'd30)};                    // samples hidden by the shrink come back
    tbl = {tbl, item_row(OP_REPORT, '0, '0)};

    foreach (tbl[i]) begin
      case (tbl[i].kind)
        ROW_PCT: write_reg(REG_PERCENTILE, tbl[i].value);
        ROW_CAP: write_reg(REG_CAPACITY, tbl[i].value);
        default: begin
          send(tbl[i].item);
          // a typed row must agree with the shadow prediction as well
          if (tbl[i].typed && report_q[$] !== tbl[i].result) begin
            errors++;
            $display("row %0d: typed result %p differs from prediction %p",
                     i, tbl[i].result, report_q[$]);
            report_q[$] = tbl[i].result;
          end
        end
      endcase
    end

    // Random phases; phase 3 runs without idling, phase 5 adds the long hold-off
    // on a small window so a finished report waits behind the held result.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: cap = 1;
        1: cap = WMAX;
        2: cap = 2047;
        5: cap = 4;
        default: cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                    : $urandom_range(0, 40);
      endcase
      write_reg(REG_CAPACITY, cap[CFG_DATA_W-1:0]);
      case ($urandom_range(0, 5))
        0: write_reg(REG_PERCENTILE, 17'd0);
        1: write_reg(REG_PERCENTILE, FULL_SCALE_Q16);
        2: write_reg(REG_PERCENTILE, CFG_DATA_W'($urandom_range(65537, 131071)));
        default: write_reg(REG_PERCENTILE, CFG_DATA_W'($urandom_range(1, 65535)));
      endcase
      quiet = (ph == 3);
      if (ph == 5) hold_req = 1'b1;
      // large windows make reports slow, so keep them rare there
      rep_pct = (eff_cap() > 64) ? 4 : 25;
      n_items = 38;
      for (int k = 0; k < n_items; k++) begin
        it.op = ($urandom_range(0, 99) < rep_pct) ? OP_REPORT : OP_PUSH;
        it.rx_sample = pick_sample();
        it.tx_sample = pick_sample();
        send(it);
      end
      it.op = OP_REPORT;
      send(it);
    end
    quiet = 1'b0;

    go_idle();
    repeat (40) @(posedge clk);
    $display("covered %0d pushes, %0d reports (%0d results seen), %0d register writes",
             pushes, reports, results_seen, cfg_writes);
    $display("long output hold-off %0s; %0d mismatches", hold_seen ? "done" : "missed",
             mismatches);
    if (errors == 0 && report_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
